@@ rtl/core/pps_pkg.sv @@
`timescale 1ns / 1ps

package pps_pkg;

   // Default size of the job table.
   localparam int SLOTS_DEFAULT = 16;

   // Field widths of the request and response items.
   localparam int FUNC_W       = 2;
   localparam int SLOT_FIELD_W = 4;
   localparam int ID_W         = 8;
   localparam int ARR_W        = 16;
   localparam int BURST_W      = 16;
   localparam int PRIO_W       = 8;
   localparam int TIME_W       = 32;

   // Stream bus widths; the tdata widths are padded to whole bytes.
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = FUNC_W;
   localparam int RSP_TDATA_W = 144;
   localparam int RSP_TUSER_W = 2;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Register port geometry; the word index sits above the byte offset.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_MODE_WORD = 1'b0;

   // One job table entry as it is held in the slot memory.
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] remaining;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

@@ rtl/core/pps_ram.sv @@
`timescale 1ns / 1ps

module pps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/priority_process_scheduler_top.sv @@
// Priority process scheduler.
// The req stream carries one command per transfer, selected by req_tuser: load a job
// into a table slot, advance time by one tick, or clear the table and the time.
// Loads, clears and unused codes give no response. A tick gives
// exactly one rsp transfer: the time, the job that ran (or idle), completion figures
// when that job finished, and a flag that every loaded job is done.
// A tick walks the whole table through the single read port of the slot memory, one
// slot per cycle, to find the best eligible job, then reads, updates and writes back
// that one entry and works out turnaround and waiting time on one shared subtractor.
// Its steps are scan, drain, fetch, execute, calc and emit; a held job that simply
// keeps running in non-preemptive mode skips the scan and the drain. req_tready is
// high only between commands. The response sits in an output register, so loads
// and clears are taken while it waits; a later tick that has its own result ready
// holds in its last step until rsp_tready frees the register. The preemptive_mode
// register lies at byte address 0 and must be written only while idle by the user;
// the block itself does not enforce it. Reset empties the table, zeroes the time
// and the mode, and drops any response. Slot memory contents need no clearing;
// only the valid and done bits are reset.
`timescale 1ns / 1ps

module priority_process_scheduler_top #(
   parameter int SLOTS = pps_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // slot[3:0], job_id[11:4], arrival[27:12], burst[43:28], prio[51:44], zero pad
   input  logic [pps_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // func[1:0]
   input  logic [pps_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // Response stream.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tick_time[31:0], running_id[39:32], completion[71:40], turnaround[103:72],
   // waiting[135:104], all_done[136], zero pad
   output logic [pps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // busy_res[0], finished[1]
   output logic [pps_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   // Register port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import pps_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int LW = SLOT_FIELD_W + SW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_EXEC,
      ST_CALC,
      ST_EMIT
   } state_type;

   // Control state.
   state_type            state_ff, state_in;
   logic                 mode_ff, mode_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    comp_ff, comp_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [SLOTS-1:0]     done_ff, done_in;
   logic [CW-1:0]        pending_ff, pending_in;
   logic                 holder_active_ff, holder_active_in;
   logic [SW-1:0]        holder_slot_ff, holder_slot_in;
   logic [SW-1:0]        scan_idx_ff, scan_idx_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [SW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 found_ff, found_in;
   logic [SW-1:0]        pick_ff, pick_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Working data of the current tick.
   logic [PRIO_W-1:0]    best_prio_ff, best_prio_in;
   logic [ARR_W-1:0]     best_arr_ff, best_arr_in;
   logic [ID_W-1:0]      run_id_ff, run_id_in;
   logic [BURST_W-1:0]   burst_ff, burst_in;
   logic                 fin_ff, fin_in;
   logic [TIME_W-1:0]    turn_ff, turn_in;
   logic [TIME_W-1:0]    wait_ff, wait_in;

   // Response register.
   logic [TIME_W-1:0]    out_time_ff;
   logic                 out_busy_ff;
   logic [ID_W-1:0]      out_id_ff;
   logic                 out_fin_ff;
   logic [TIME_W-1:0]    out_comp_ff;
   logic [TIME_W-1:0]    out_turn_ff;
   logic [TIME_W-1:0]    out_wait_ff;
   logic                 out_done_ff;
   logic                 out_load;

   // Request fields.
   logic [FUNC_W-1:0]    req_func;
   logic [SLOT_FIELD_W-1:0] req_slot;
   logic [ID_W-1:0]      req_job_id;
   logic [ARR_W-1:0]     req_arrival;
   logic [BURST_W-1:0]   req_burst;
   logic [PRIO_W-1:0]    req_prio;
   logic                 req_accept;
   logic [LW-1:0]        slot_wide;
   logic [SW-1:0]        load_idx;
   logic                 load_in_range;
   logic [BURST_W-1:0]   burst_fixed;

   // Slot memory ports.
   logic                 ram_wr_en;
   logic [SW-1:0]        ram_wr_addr;
   slot_entry_type       ram_wr_data;
   logic                 ram_rd_en;
   logic [SW-1:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_raw;
   slot_entry_type       rd_entry;

   // Scan compare and shared subtractor.
   logic                 arrived;
   logic                 eligible;
   logic                 better;
   logic [BURST_W-1:0]   rem_next;
   logic [TIME_W-1:0]    sub_a;
   logic [TIME_W-1:0]    sub_b;
   logic [TIME_W-1:0]    sub_res;
   logic                 csr_write;

   assign req_func    = req_tuser[FUNC_W-1:0];
   assign req_slot    = req_tdata[3:0];
   assign req_job_id  = req_tdata[11:4];
   assign req_arrival = req_tdata[27:12];
   assign req_burst   = req_tdata[43:28];
   assign req_prio    = req_tdata[51:44];

   assign req_tready    = (state_ff == ST_IDLE);
   assign req_accept    = req_tvalid && req_tready;
   assign slot_wide     = LW'(req_slot);
   assign load_idx      = slot_wide[SW-1:0];
   assign load_in_range = (slot_wide < LW'(SLOTS));
   assign burst_fixed   = (req_burst == '0) ? BURST_W'(1) : req_burst;

   pps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign rd_entry = slot_entry_type'(ram_rd_raw);

   // Scan compare: the entry read last cycle against the best one so far.
   assign arrived  = (now_ff[TIME_W-1:ARR_W] != '0) || (rd_entry.arrival <= now_ff[ARR_W-1:0]);
   assign eligible = valid_ff[cmp_idx_ff] && !done_ff[cmp_idx_ff] && arrived;
   assign better   = !found_ff || (rd_entry.prio < best_prio_ff) ||
                     ((rd_entry.prio == best_prio_ff) && (rd_entry.arrival < best_arr_ff));

   // Remaining service after one tick of the picked job.
   assign rem_next = (rd_entry.remaining > BURST_W'(1)) ?
                     (rd_entry.remaining - BURST_W'(1)) : '0;

   // Shared subtractor: turnaround in the execute step, waiting time in the next.
   assign sub_a   = (state_ff == ST_EXEC) ? comp_ff : turn_ff;
   assign sub_b   = (state_ff == ST_EXEC) ? TIME_W'(rd_entry.arrival) : TIME_W'(burst_ff);
   assign sub_res = sub_a - sub_b;

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_MODE_WORD) ? CSR_DATA_W'(mode_ff) : '0;

   // Sequencer next-state logic.
   always_comb begin
      state_in         = state_ff;
      mode_in          = mode_ff;
      now_in           = now_ff;
      comp_in          = comp_ff;
      valid_in         = valid_ff;
      done_in          = done_ff;
      pending_in       = pending_ff;
      holder_active_in = holder_active_ff;
      holder_slot_in   = holder_slot_ff;
      scan_idx_in      = scan_idx_ff;
      cmp_valid_in     = cmp_valid_ff;
      cmp_idx_in       = cmp_idx_ff;
      found_in         = found_ff;
      pick_in          = pick_ff;
      rsp_valid_in     = rsp_valid_ff;
      best_prio_in     = best_prio_ff;
      best_arr_in      = best_arr_ff;
      run_id_in        = run_id_ff;
      burst_in         = burst_ff;
      fin_in           = fin_ff;
      turn_in          = turn_ff;
      wait_in          = wait_ff;
      out_load         = 1'b0;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = load_idx;
      ram_wr_data      = '{id: req_job_id, arrival: req_arrival, burst: burst_fixed,
                           prio: req_prio, remaining: burst_fixed};
      ram_rd_en        = 1'b0;
      ram_rd_addr      = scan_idx_ff;

      if (csr_write && (csr_paddr[2] == CSR_MODE_WORD)) begin
         mode_in = csr_pwdata[0];
      end

      // The response register frees up on its transfer.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_func)
                  FUNC_LOAD: begin
                     if (load_in_range) begin
                        ram_wr_en = 1'b1;
                        if (!(valid_ff[load_idx] && !done_ff[load_idx])) begin
                           pending_in = pending_ff + CW'(1);
                        end
                        valid_in[load_idx] = 1'b1;
                        done_in[load_idx]  = 1'b0;
                        if (holder_active_ff && (holder_slot_ff == load_idx)) begin
                           holder_active_in = 1'b0;
                        end
                     end
                  end
                  FUNC_TICK: begin
                     comp_in = now_ff + TIME_W'(1);
                     if (!mode_ff && holder_active_ff && valid_ff[holder_slot_ff] &&
                         !done_ff[holder_slot_ff]) begin
                        found_in = 1'b1;
                        pick_in  = holder_slot_ff;
                        state_in = ST_FETCH;
                     end else begin
                        found_in    = 1'b0;
                        scan_idx_in = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  FUNC_CLEAR: begin
                     valid_in         = '0;
                     done_in          = '0;
                     pending_in       = '0;
                     now_in           = '0;
                     holder_active_in = 1'b0;
                     holder_slot_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            ram_rd_en    = 1'b1;
            ram_rd_addr  = scan_idx_ff;
            cmp_valid_in = 1'b1;
            cmp_idx_in   = scan_idx_ff;
            scan_idx_in  = scan_idx_ff + SW'(1);
            if (scan_idx_ff == SW'(SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmp_valid_in = 1'b0;
            state_in     = ST_FETCH;
         end
         ST_FETCH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pick_ff;
            state_in    = ST_EXEC;
         end
         ST_EXEC: begin
            fin_in    = 1'b0;
            run_id_in = found_ff ? rd_entry.id : '0;
            burst_in  = rd_entry.burst;
            turn_in   = sub_res;
            if (found_ff) begin
               ram_wr_en             = 1'b1;
               ram_wr_addr           = pick_ff;
               ram_wr_data           = rd_entry;
               ram_wr_data.remaining = rem_next;
               holder_active_in      = 1'b1;
               holder_slot_in        = pick_ff;
               if (rem_next == '0) begin
                  done_in[pick_ff] = 1'b1;
                  holder_active_in = 1'b0;
                  pending_in       = pending_ff - CW'(1);
                  fin_in           = 1'b1;
               end
            end
            state_in = ST_CALC;
         end
         ST_CALC: begin
            wait_in  = sub_res;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               now_in       = comp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Keep the best eligible entry seen during the scan.
      if (cmp_valid_ff && eligible && better) begin
         found_in     = 1'b1;
         pick_in      = cmp_idx_ff;
         best_prio_in = rd_entry.prio;
         best_arr_in  = rd_entry.arrival;
      end
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         mode_ff          <= 1'b0;
         now_ff           <= '0;
         valid_ff         <= '0;
         done_ff          <= '0;
         pending_ff       <= '0;
         holder_active_ff <= 1'b0;
         holder_slot_ff   <= '0;
         scan_idx_ff      <= '0;
         cmp_valid_ff     <= 1'b0;
         found_ff         <= 1'b0;
         pick_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         mode_ff          <= mode_in;
         now_ff           <= now_in;
         valid_ff         <= valid_in;
         done_ff          <= done_in;
         pending_ff       <= pending_in;
         holder_active_ff <= holder_active_in;
         holder_slot_ff   <= holder_slot_in;
         scan_idx_ff      <= scan_idx_in;
         cmp_valid_ff     <= cmp_valid_in;
         found_ff         <= found_in;
         pick_ff          <= pick_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Working data and response payload.
   always_ff @(posedge clock) begin
      comp_ff      <= comp_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_prio_ff <= best_prio_in;
      best_arr_ff  <= best_arr_in;
      run_id_ff    <= run_id_in;
      burst_ff     <= burst_in;
      fin_ff       <= fin_in;
      turn_ff      <= turn_in;
      wait_ff      <= wait_in;
      if (out_load) begin
         out_time_ff <= now_ff;
         out_busy_ff <= found_ff;
         out_id_ff   <= run_id_ff;
         out_fin_ff  <= fin_ff;
         out_comp_ff <= fin_ff ? comp_ff : '0;
         out_turn_ff <= fin_ff ? turn_ff : '0;
         out_wait_ff <= fin_ff ? wait_ff : '0;
         out_done_ff <= (pending_ff == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, out_done_ff, out_wait_ff, out_turn_ff, out_comp_ff,
                        out_id_ff, out_time_ff};
   assign rsp_tuser  = {out_fin_ff, out_busy_ff};

   // The count of unfinished jobs never exceeds the table.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CW'(SLOTS))
      else $error("unfinished job count exceeds the table size");

   // A held job is always loaded and still unfinished.
   a_holder_live: assert property (@(posedge clock) disable iff (reset)
      holder_active_ff |-> (valid_ff[holder_slot_ff] && !done_ff[holder_slot_ff]))
      else $error("held slot is empty or already done");

   // Only a job that ran can finish.
   a_fin_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_fin_ff) |-> out_busy_ff)
      else $error("finished reported on an idle tick");

   // A tick keeps the sequencer busy, so req_tready drops after it is accepted.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_func == FUNC_TICK)) |=> !req_tready)
      else $error("request taken during a tick");

   // The slot memory is written only by loads or by the execute step.
   a_wr_states: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ((state_ff == ST_IDLE) || (state_ff == ST_EXEC)))
      else $error("slot memory written outside load or execute");

endmodule

@@ tb/tb_priority_process_scheduler_top.sv @@
`timescale 1ns / 1ps

module tb_priority_process_scheduler_top;
   import pps_pkg::*;

   localparam int TABLE_SLOTS = SLOTS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 400000;
   // A tick walks the whole table before the block is idle again; allow a margin on top.
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 175;
   localparam int STALL_CYCLES = 500;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR = {CSR_MODE_WORD, 2'b00};

   // One command on the request stream.
   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [ID_W-1:0]         job_id;
      logic [ARR_W-1:0]        arrival;
      logic [BURST_W-1:0]      burst;
      logic [PRIO_W-1:0]       prio;
   } sched_cmd_type;

   // One tick report on the response stream.
   typedef struct packed {
      logic [TIME_W-1:0] tick_time;
      logic              busy;
      logic [ID_W-1:0]   running_id;
      logic              finished;
      logic [TIME_W-1:0] completion;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              all_done;
   } tick_report_type;

   // One row of the directed script.
   typedef struct packed {
      logic            mode;
      sched_cmd_type   cmd;
      logic            typed;
      tick_report_type report;
   } script_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;
   logic [REQ_TUSER_W-1:0]   req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic [RSP_TUSER_W-1:0]   rsp_tuser;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // Shadow copy of the scheduler state.
   slot_entry_type    job_table [TABLE_SLOTS];
   logic              job_valid [TABLE_SLOTS];
   logic              job_done [TABLE_SLOTS];
   logic [TIME_W-1:0] sched_now;
   logic              hold_active;
   int                hold_slot;
   logic              mode_preempt;

   tick_report_type tick_reports_due[$];
   script_row_type  script[$];

   int          send_idle_pct;
   int          recv_idle_pct;
   int          rsp_hold_cycles;
   int          mismatches;
   int          transfers_sent;
   int          reports_checked;
   int          completions_seen;
   int unsigned cycle_count = 0;

   priority_process_scheduler_top #(
      .SLOTS(TABLE_SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: run stopped after %0d cycles, %0d reports still due", $time,
               cycle_count, tick_reports_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Empties the job table and restarts time.
   function automatic void clear_job_table();
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         job_table[s] = '0;
         job_valid[s] = 1'b0;
         job_done[s]  = 1'b0;
      end
      sched_now   = '0;
      hold_active = 1'b0;
      hold_slot   = 0;
   endfunction

   // True when no loaded job is still waiting for service.
   function automatic bit table_finished();
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         if (job_valid[s] && !job_done[s]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Applies one accepted command to the shadow state. Returns 1 and fills the
   // report when the command is a tick.
   function automatic bit predict_schedule(input sched_cmd_type c,
                                           output tick_report_type r);
      logic [BURST_W-1:0] b;
      logic [BURST_W-1:0] rem;
      bit                 found;
      int                 pick;
      int                 s;
      r     = '0;
      found = 1'b0;
      pick  = 0;
      s     = int'(c.slot);
      case (c.func)
         FUNC_LOAD: begin
            if (s < TABLE_SLOTS) begin
               // A zero burst is stored as one tick of service.
               b = (c.burst == '0) ? BURST_W'(1) : c.burst;
               job_valid[s]           = 1'b1;
               job_done[s]            = 1'b0;
               job_table[s].id        = c.job_id;
               job_table[s].arrival   = c.arrival;
               job_table[s].burst     = b;
               job_table[s].prio      = c.prio;
               job_table[s].remaining = b;
               if (hold_active && hold_slot == s) hold_active = 1'b0;
            end
            return 1'b0;
         end
         FUNC_CLEAR: begin
            clear_job_table();
            return 1'b0;
         end
         FUNC_TICK: begin
         end
         default: begin
            return 1'b0;
         end
      endcase

      // In run-to-completion mode a held job keeps the processor.
      if (!mode_preempt && hold_active && job_valid[hold_slot] && !job_done[hold_slot]) begin
         found = 1'b1;
         pick  = hold_slot;
      end else begin
         for (int k = 0; k < TABLE_SLOTS; k++) begin
            if (!job_valid[k] || job_done[k] ||
                TIME_W'(job_table[k].arrival) > sched_now) continue;
            if (!found || job_table[k].prio < job_table[pick].prio ||
                (job_table[k].prio == job_table[pick].prio &&
                 job_table[k].arrival < job_table[pick].arrival)) begin
               found = 1'b1;
               pick  = k;
            end
         end
      end

      r.tick_time = sched_now;
      r.busy      = found;
      if (found) begin
         r.running_id = job_table[pick].id;
         rem = (job_table[pick].remaining > 1) ? job_table[pick].remaining - 1'b1 : '0;
         job_table[pick].remaining = rem;
         hold_active = 1'b1;
         hold_slot   = pick;
         if (rem == '0) begin
            job_done[pick] = 1'b1;
            hold_active    = 1'b0;
            r.finished     = 1'b1;
            r.completion   = sched_now + 1;
            r.turnaround   = r.completion - TIME_W'(job_table[pick].arrival);
            r.waiting      = r.turnaround - TIME_W'(job_table[pick].burst);
         end
      end
      sched_now  = sched_now + 1;
      r.all_done = table_finished();
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Offers one command, waits for its transfer and records what it should produce.
   task automatic send_command(input sched_cmd_type c, input logic typed,
                               input tick_report_type typed_report);
      tick_report_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.func;
      req_tdata  <= {4'b0000, c.prio, c.burst, c.arrival, c.job_id, c.slot};
      do @(posedge clock); while (!req_tready);
      if (predict_schedule(c, predicted)) begin
         tick_reports_due.push_back(typed ? typed_report : predicted);
      end
      transfers_sent++;
      @(negedge clock);
   endtask

   // Stops offering and waits until every report has come back and the block is idle.
   task automatic drain_scheduler();
      req_tvalid <= 1'b0;
      while (tick_reports_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register access: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= is_write ? data : '0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         if (addr == MODE_ADDR) mode_preempt = data[0];
      end else begin
         check_field("preemptive_mode readback", data, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_mode(input logic m);
      drain_scheduler();
      csr_access(1'b1, MODE_ADDR, {31'b0, m});
      csr_access(1'b0, MODE_ADDR, {31'b0, m});
   endtask

   function automatic void add_cmd(input logic m, input logic [FUNC_W-1:0] f, input int s,
                                   input int id, input int arr, input int bur, input int pr);
      script_row_type row;
      row = '0;
      row.mode        = m;
      row.cmd.func    = f;
      row.cmd.slot    = SLOT_FIELD_W'(s);
      row.cmd.job_id  = ID_W'(id);
      row.cmd.arrival = ARR_W'(arr);
      row.cmd.burst   = BURST_W'(bur);
      row.cmd.prio    = PRIO_W'(pr);
      script.push_back(row);
   endfunction

   // A tick whose report is written out in full.
   function automatic void add_checked_tick(input logic m, input int unsigned t,
                                            input logic busy, input int id,
                                            input logic fin, input int unsigned comp,
                                            input int unsigned turn, input int unsigned wt,
                                            input logic done);
      script_row_type row;
      row = '0;
      row.mode              = m;
      row.cmd.func          = FUNC_TICK;
      row.typed             = 1'b1;
      row.report.tick_time  = t;
      row.report.busy       = busy;
      row.report.running_id = ID_W'(id);
      row.report.finished   = fin;
      row.report.completion = comp;
      row.report.turnaround = turn;
      row.report.waiting    = wt;
      row.report.all_done   = done;
      script.push_back(row);
   endfunction

   function automatic sched_cmd_type random_load();
      sched_cmd_type c;
      c.func    = FUNC_LOAD;
      c.slot    = SLOT_FIELD_W'($urandom_range(0, TABLE_SLOTS - 1));
      c.job_id  = ID_W'($urandom);
      c.arrival = ($urandom_range(0, 9) == 0) ? ARR_W'($urandom) : ARR_W'($urandom_range(0, 8));
      c.burst   = ($urandom_range(0, 29) == 0) ? BURST_W'($urandom) :
                                                  BURST_W'($urandom_range(0, 6));
      c.prio    = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
      return c;
   endfunction

   // A well-formed batch: usually a clear, then a few loads, then ticks until the jobs are
   // all served or 40 ticks have gone by. Stray reloads and unused codes are mixed in now and then.
   task automatic run_job_batch();
      sched_cmd_type   c;
      tick_report_type none;
      int              ticks;
      none = '0;
      if ($urandom_range(0, 9) != 0) begin
         c = sched_cmd_type'({$urandom, $urandom});
         c.func = FUNC_CLEAR;
         send_command(c, 1'b0, none);
      end
      repeat ($urandom_range(1, 6)) send_command(random_load(), 1'b0, none);
      ticks = 0;
      while (ticks < 40 && !(ticks > 0 && table_finished())) begin
         if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1) != 0) begin
               c = sched_cmd_type'({$urandom, $urandom});
               c.func = FUNC_SPARE;
            end else begin
               c = random_load();
            end
            send_command(c, 1'b0, none);
         end
         c = sched_cmd_type'({$urandom, $urandom});
         c.func = FUNC_TICK;
         send_command(c, 1'b0, none);
         ticks++;
      end
   endtask

   // Response side: random or forced back-pressure, then check each transfer.
   initial begin
      tick_report_type want;
      tick_report_type got;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.tick_time  = rsp_tdata[31:0];
            got.running_id = rsp_tdata[39:32];
            got.completion = rsp_tdata[71:40];
            got.turnaround = rsp_tdata[103:72];
            got.waiting    = rsp_tdata[135:104];
            got.all_done   = rsp_tdata[136];
            got.busy       = rsp_tuser[0];
            got.finished   = rsp_tuser[1];
            if (tick_reports_due.size() == 0) begin
               $display("%0t: expected no tick report, got tick_time %0h running_id %0h",
                        $time, got.tick_time, got.running_id);
               mismatches++;
            end else begin
               want = tick_reports_due.pop_front();
               check_field("tick_time", want.tick_time, got.tick_time);
               check_field("busy_res", 32'(want.busy), 32'(got.busy));
               check_field("running_id", 32'(want.running_id), 32'(got.running_id));
               check_field("finished", 32'(want.finished), 32'(got.finished));
               check_field("completion", want.completion, got.completion);
               check_field("turnaround", want.turnaround, got.turnaround);
               check_field("waiting", want.waiting, got.waiting);
               check_field("all_done", 32'(want.all_done), 32'(got.all_done));
               reports_checked++;
               if (want.finished) completions_seen++;
            end
         end
      end
   end

   initial begin
      int phase_start;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      send_idle_pct   = 25;
      recv_idle_pct   = 87;
      rsp_hold_cycles = 0;
      mismatches      = 0;
      transfers_sent  = 0;
      reports_checked = 0;
      completions_seen = 0;
      mode_preempt    = 1'b0;
      clear_job_table();
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_mode(1'b0);

      // Directed script, run-to-completion mode first.
      add_checked_tick(1'b0, 0, 1'b0, 0, 1'b0, 0, 0, 0, 1'b1);      // empty table is idle
      add_cmd(1'b0, FUNC_SPARE, 15, 255, 65535, 65535, 255);        // unused code, ignored
      add_cmd(1'b0, FUNC_LOAD, 15, 255, 0, 0, 255);                 // zero burst becomes one
      add_checked_tick(1'b0, 1, 1'b1, 255, 1'b1, 2, 2, 1, 1'b1);
      add_cmd(1'b0, FUNC_CLEAR, 0, 0, 0, 0, 0);
      add_cmd(1'b0, FUNC_LOAD, 0, 0, 65535, 65535, 0);              // never arrives
      add_checked_tick(1'b0, 0, 1'b0, 0, 1'b0, 0, 0, 0, 1'b0);
      add_cmd(1'b0, FUNC_LOAD, 1, 8'h11, 0, 2, 5);
      add_cmd(1'b0, FUNC_LOAD, 2, 8'h22, 2, 1, 1);
      add_cmd(1'b0, FUNC_TICK, 0, 0, 0, 0, 0);
      add_cmd(1'b0, FUNC_TICK, 0, 0, 0, 0, 0);                      // held despite better prio
      add_cmd(1'b0, FUNC_LOAD, 3, 8'h33, 0, 3, 0);
      add_cmd(1'b0, FUNC_TICK, 0, 0, 0, 0, 0);
      add_cmd(1'b0, FUNC_LOAD, 3, 8'h44, 1, 1, 200);                // reload drops the hold
      add_cmd(1'b0, FUNC_LOAD, 4, 8'h55, 1, 1, 200);
      add_cmd(1'b0, FUNC_LOAD, 5, 8'h66, 0, 1, 200);
      add_cmd(1'b0, FUNC_TICK, 0, 0, 0, 0, 0);
      add_cmd(1'b0, FUNC_TICK, 0, 0, 0, 0, 0);                      // earlier arrival wins
      add_cmd(1'b0, FUNC_TICK, 0, 0, 0, 0, 0);                      // lower slot wins
      add_cmd(1'b0, FUNC_TICK, 0, 0, 0, 0, 0);
      // Preemptive mode, then back with a job still held.
      add_cmd(1'b1, FUNC_CLEAR, 0, 0, 0, 0, 0);
      add_cmd(1'b1, FUNC_LOAD, 0, 8'hA0, 0, 3, 7);
      add_cmd(1'b1, FUNC_TICK, 0, 0, 0, 0, 0);
      add_cmd(1'b1, FUNC_LOAD, 1, 8'hA1, 0, 1, 2);
      add_cmd(1'b1, FUNC_TICK, 0, 0, 0, 0, 0);
      add_cmd(1'b1, FUNC_TICK, 0, 0, 0, 0, 0);
      add_cmd(1'b1, FUNC_LOAD, 2, 8'hA2, 0, 1, 0);
      add_cmd(1'b0, FUNC_TICK, 0, 0, 0, 0, 0);                      // hold honored again

      foreach (script[i]) begin
         if (script[i].mode != mode_preempt) set_mode(script[i].mode);
         send_command(script[i].cmd, script[i].typed, script[i].report);
      end

      // Random batches, sender mostly busy and receiver mostly stalling.
      set_mode(1'b1);
      phase_start = transfers_sent;
      while (transfers_sent - phase_start < PHASE_ITEMS) run_job_batch();

      // The other way round.
      drain_scheduler();
      send_idle_pct = 87;
      recv_idle_pct = 25;
      set_mode(1'b0);
      phase_start = transfers_sent;
      while (transfers_sent - phase_start < PHASE_ITEMS) run_job_batch();

      // No idling; the first batch runs into a long response stall.
      drain_scheduler();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      rsp_hold_cycles = STALL_CYCLES;
      phase_start = transfers_sent;
      run_job_batch();
      while (transfers_sent - phase_start < PHASE_ITEMS) begin
         set_mode(logic'($urandom_range(0, 1)));
         run_job_batch();
      end

      drain_scheduler();
      mismatches += tick_reports_due.size();
      $display("Covered %0d command transfers and %0d tick reports, %0d of them completions,",
               transfers_sent, reports_checked, completions_seen);
      $display("in both scheduling modes, with idling on either side and a %0d-cycle stall.",
               STALL_CYCLES);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/priority_process_scheduler_top.sv
tb/tb_priority_process_scheduler_top.sv
